// File: hdl/websocket_frame_deframer_macros.svh
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// assertion helpers, clocked on clock and muted while reset is high

`define WSD_ASSERT_IMPL(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("wsd assertion failed");

`define WSD_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("wsd assertion failed");

`define WSD_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("wsd assertion failed");

`endif

// File: hdl/wsd_pkg.sv
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_EMPTY,
      KIND_CLOSE,
      KIND_VIOLATION
   } kind_type;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // extended length bytes still to come, minus one
   localparam logic [2:0] EXT_LEFT_16 = 3'd1;
   localparam logic [2:0] EXT_LEFT_64 = 3'd7;

   localparam logic [1:0] KEY_LAST_POS = 2'd3;

   typedef struct packed {
      kind_type   kind;
      logic       is_ping;
      logic       fin;
      logic [7:0] data;
      logic [7:0] key;
      logic       last;
   } cmd_type;

endpackage

// File: hdl/wsd_if.sv
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic       is_ping;
   logic       fin_flag;
   logic [7:0] payload_byte;
   logic       frame_last;

   modport source (output valid, output result_kind, output is_ping, output fin_flag,
                   output payload_byte, output frame_last, input ready);
   modport sink   (input valid, input result_kind, input is_ping, input fin_flag,
                   input payload_byte, input frame_last, output ready);
endinterface

// File: hdl/wsd_front.sv
`include "websocket_frame_deframer_macros.svh"

module wsd_front (
   input  logic            clock,
   input  logic            reset,
   wsd_req_if.sink         req_chan,
   input  logic            queue_full,
   output logic            push,
   output wsd_pkg::cmd_type push_cmd
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic [2:0]  len_left_ff, len_left_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_pos_ff, key_pos_in;

   logic        fire;
   logic [7:0]  in_byte;
   logic        is_ping_op;
   logic        is_close_op;
   logic        reported;
   logic        pay_last;
   logic [7:0]  key_byte;

   assign req_chan.ready = !queue_full;
   assign fire           = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.data_byte;

   assign is_ping_op  = (opcode_ff == OP_PING);
   assign is_close_op = (opcode_ff == OP_CLOSE);
   assign reported    = (opcode_ff == OP_TEXT) || is_ping_op;
   assign pay_last    = (remaining_ff == 64'd1);

   // first key byte sits in the high byte
   always_comb begin
      unique case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_HDR0: begin
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               priority if (!in_byte[7]) begin
                  phase_in = PH_HALT;
               end else if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
                  phase_in = PH_EXTLEN;
               end else begin
                  phase_in = PH_MASK;
               end
            end
            PH_EXTLEN: begin
               if (len_left_ff == 3'd0) begin
                  phase_in = PH_MASK;
               end
            end
            PH_MASK: begin
               if (key_pos_ff == KEY_LAST_POS) begin
                  priority if (remaining_ff != 64'd0) begin
                     phase_in = PH_PAYLOAD;
                  end else if (is_close_op) begin
                     phase_in = PH_HALT;
                  end else begin
                     phase_in = PH_HDR0;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (pay_last) begin
                  phase_in = is_close_op ? PH_HALT : PH_HDR0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result requests handed to the queue
   always_comb begin
      push     = 1'b0;
      push_cmd = '{kind: KIND_PAYLOAD, is_ping: 1'b0, fin: fin_ff,
                   data: 8'd0, key: 8'd0, last: 1'b1};
      if (fire) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (!in_byte[7]) begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_VIOLATION;
               end
            end
            PH_MASK: begin
               if (key_pos_ff == KEY_LAST_POS && remaining_ff == 64'd0) begin
                  priority if (reported) begin
                     push             = 1'b1;
                     push_cmd.kind    = KIND_EMPTY;
                     push_cmd.is_ping = is_ping_op;
                  end else if (is_close_op) begin
                     push          = 1'b1;
                     push_cmd.kind = KIND_CLOSE;
                  end else begin
                     push = 1'b0;
                  end
               end
            end
            PH_PAYLOAD: begin
               priority if (reported) begin
                  push             = 1'b1;
                  push_cmd.kind    = KIND_PAYLOAD;
                  push_cmd.is_ping = is_ping_op;
                  push_cmd.data    = in_byte;
                  push_cmd.key     = key_byte;
                  push_cmd.last    = pay_last;
               end else if (is_close_op && pay_last) begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_CLOSE;
               end else begin
                  push = 1'b0;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // header fields, length and key
   always_comb begin
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      len_left_in  = len_left_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      key_pos_in   = key_pos_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = in_byte[7];
               opcode_in = in_byte[3:0];
            end
            PH_HDR1: begin
               if (in_byte[7]) begin
                  key_in     = 32'd0;
                  key_pos_in = 2'd0;
                  priority if (in_byte[6:0] == LEN_CODE_16) begin
                     remaining_in = 64'd0;
                     len_left_in  = EXT_LEFT_16;
                  end else if (in_byte[6:0] == LEN_CODE_64) begin
                     remaining_in = 64'd0;
                     len_left_in  = EXT_LEFT_64;
                  end else begin
                     remaining_in = {57'd0, in_byte[6:0]};
                  end
               end
            end
            PH_EXTLEN: begin
               remaining_in = {remaining_ff[55:0], in_byte};
               if (len_left_ff != 3'd0) begin
                  len_left_in = len_left_ff - 3'd1;
               end
            end
            PH_MASK: begin
               key_in     = {key_ff[23:0], in_byte};
               key_pos_in = key_pos_ff + 2'd1;
            end
            PH_PAYLOAD: begin
               key_pos_in   = key_pos_ff + 2'd1;
               remaining_in = remaining_ff - 64'd1;
            end
            default: begin
               key_pos_in = key_pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         len_left_ff <= 3'd0;
         key_pos_ff  <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         len_left_ff <= len_left_in;
         key_pos_ff  <= key_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff    <= opcode_in;
      fin_ff       <= fin_in;
      remaining_ff <= remaining_in;
      key_ff       <= key_in;
   end

   `WSD_ASSERT_NEXT(a_halt_sticky, phase_ff == PH_HALT, phase_ff == PH_HALT)
   `WSD_ASSERT_IMPL(a_payload_nonzero, phase_ff == PH_PAYLOAD, remaining_ff != 64'd0)

endmodule

// File: hdl/wsd_queue.sv
`include "websocket_frame_deframer_macros.svh"

module wsd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wsd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output wsd_pkg::cmd_type head_cmd
);
   import wsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `WSD_ASSERT_NEVER(a_no_overflow, push && full)
   `WSD_ASSERT_NEVER(a_no_underflow, pop && !head_valid)

endmodule

// File: hdl/wsd_back.sv
`include "websocket_frame_deframer_macros.svh"

module wsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  wsd_pkg::cmd_type head_cmd,
   output logic             pop,
   wsd_rsp_if.source        rsp_chan
);
   import wsd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   kind_type   kind_ff, kind_in;
   logic       ping_ff, ping_in;
   logic       fin_ff, fin_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   // output register takes the queue head when empty or being drained
   assign pop = head_valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      ping_in      = ping_ff;
      fin_in       = fin_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         kind_in      = head_cmd.kind;
         ping_in      = head_cmd.is_ping;
         fin_in       = head_cmd.fin;
         byte_in      = (head_cmd.kind == KIND_PAYLOAD) ? (head_cmd.data ^ head_cmd.key)
                                                        : 8'd0;
         last_in      = head_cmd.last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      ping_ff <= ping_in;
      fin_ff  <= fin_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_kind  = kind_ff;
   assign rsp_chan.is_ping      = ping_ff;
   assign rsp_chan.fin_flag     = fin_ff;
   assign rsp_chan.payload_byte = byte_ff;
   assign rsp_chan.frame_last   = last_ff;

   `WSD_ASSERT_NEXT(a_pop_shows, pop, out_valid_ff)

endmodule

// File: hdl/websocket_frame_deframer.sv
// WebSocket client-to-server deframer: takes one stream byte per clock on req_chan while
// its result queue has room and returns unmasked text and ping payload bytes, empty-frame
// marks, a close mark and an unmasked-frame violation on rsp_chan. The header parser
// handles each byte as it is taken (its 64-bit payload counter counts down once per
// payload byte), so the sustained rate is one byte per clock while the queue has room.
// Each result is written into a queue of QUEUE_DEPTH entries and then into an output
// register that drives rsp_chan; req_chan.ready falls only while that queue is full.
// After a close or a violation the block keeps taking bytes and drops them until reset.
module websocket_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan
);
   import wsd_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   wsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
